// ----- design/key_debounce_long_press_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Key debounce assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef KEY_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH
`define KEY_DEBOUNCE_LONG_PRESS_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define KDLP_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define KDLP_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- design/kdlp_pkg.sv -----
// ----------------------------------------------------------------------------
// Key debounce package
// Types, register indexes and reset values shared by the debouncer modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kdlp_pkg;

	localparam int MASK_W  = 4;
	localparam int COUNT_W = 8;
	localparam int INDEX_W = 2;

	typedef logic [MASK_W-1:0]  mask_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [INDEX_W-1:0] reg_index_t;

	localparam reg_index_t REG_PRESS_TICKS   = 2'd0;
	localparam reg_index_t REG_RELEASE_TICKS = 2'd1;
	localparam reg_index_t REG_LONG_TICKS    = 2'd2;

	localparam count_t PRESS_TICKS_RST   = 8'd10;
	localparam count_t RELEASE_TICKS_RST = 8'd10;
	localparam count_t LONG_TICKS_RST    = 8'd50;
	localparam count_t COUNT_MAX         = 8'hFF;

	typedef struct packed {
		count_t press_ticks;
		count_t release_ticks;
		count_t long_ticks;
	} kdlp_cfg_t;

	typedef struct packed {
		mask_t key_code;
		logic  long_press;
	} kdlp_res_t;

	function automatic count_t inc_sat(input count_t v);
		inc_sat = (v == COUNT_MAX) ? COUNT_MAX : count_t'(v + 8'd1);
	endfunction

endpackage

// ----- design/key_debounce_long_press_unit.sv -----
// ----------------------------------------------------------------------------
// Key debounce with long-press detection
// Four-key debouncer; one item per sample tick, one result per press.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall, key_mask): one item per sample tick,
//   carrying the mask of pressed keys.  Taken every cycle unless stalled.
//   Output channel (out_valid/out_stall, key_code, long_press): one item when
//   a press ends, giving the largest mask seen and the long-press flag.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): thresholds
//   press_ticks (0), release_ticks (1), long_ticks (2); other indexes are
//   ignored.  Write only while idle.  cfg_ready is always high.
//   A result for the tick that ends the press passes the input register, then
//   the result register.  The block takes one item per cycle unless a stalled
//   result holds the input; the press state is updated between the two.
//   Reset clears all press state and loads thresholds 10, 10 and 50.
//   While a result is stalled, ticks that end no press keep flowing; a tick
//   that ends a press waits in the input register, stalling the input.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module key_debounce_long_press_unit import kdlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  mask_t      key_mask,
	output logic       out_valid,
	input  logic       out_stall,
	output mask_t      key_code,
	output logic       long_press,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  reg_index_t cfg_index,
	input  count_t     cfg_data
);

	kdlp_cfg_t cfg;
	kdlp_res_t res;
	logic      res_valid;
	logic      out_free;

	kdlp_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kdlp_tracker u_trk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.key_mask  (key_mask),
		.cfg       (cfg),
		.out_free  (out_free),
		.res_valid (res_valid),
		.res       (res)
	);

	kdlp_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.res_valid  (res_valid),
		.res        (res),
		.out_free   (out_free),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.key_code   (key_code),
		.long_press (long_press)
	);

endmodule

// ----- design/kdlp_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Key debounce configuration registers
// Threshold registers written through the configuration channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdlp_cfg_regs import kdlp_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  reg_index_t cfg_index,
	input  count_t     cfg_data,
	output kdlp_cfg_t  cfg
);

	kdlp_cfg_t cfg_q;
	logic      wr;

	assign cfg_ready = 1'b1;
	assign wr        = cfg_valid && cfg_ready;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_ticks   <= PRESS_TICKS_RST;
			cfg_q.release_ticks <= RELEASE_TICKS_RST;
			cfg_q.long_ticks    <= LONG_TICKS_RST;
		end else if (wr) begin
			case (cfg_index)
				REG_PRESS_TICKS:   cfg_q.press_ticks   <= cfg_data;
				REG_RELEASE_TICKS: cfg_q.release_ticks <= cfg_data;
				REG_LONG_TICKS:    cfg_q.long_ticks    <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

// ----- design/kdlp_tracker.sv -----
// ----------------------------------------------------------------------------
// Key debounce press tracker
// Input register, press/release update, one item per cycle unless stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdlp_tracker import kdlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  mask_t     key_mask,
	input  kdlp_cfg_t cfg,
	input  logic      out_free,
	output logic      res_valid,
	output kdlp_res_t res
);

	logic   valid_s1;
	mask_t  mask_s1;
	logic   phase_q;
	count_t run_q;
	count_t held_q;
	mask_t  best_q;

	logic   phase_d;
	count_t run_d;
	count_t held_d;
	mask_t  best_d;

	logic   pressed;
	count_t run_inc;
	logic   fire;
	logic   advance;
	logic   accept;

	assign pressed = |mask_s1;
	assign run_inc = inc_sat(run_q);
	assign fire    = valid_s1 && phase_q && !pressed && (run_inc >= cfg.release_ticks);
	// an item with no result may pass while a result waits downstream
	assign advance = valid_s1 && (out_free || !fire);
	assign in_stall = valid_s1 && !advance;
	assign accept  = in_valid && !in_stall;

	assign res_valid      = advance && fire;
	assign res.key_code   = best_q;
	assign res.long_press = held_q > cfg.long_ticks;

	always_comb begin
		phase_d = phase_q;
		run_d   = run_q;
		held_d  = held_q;
		best_d  = (pressed && mask_s1 > best_q) ? mask_s1 : best_q;
		if (!phase_q) begin
			if (pressed) begin
				run_d = run_inc;
				if (run_inc >= cfg.press_ticks) begin
					phase_d = 1'b1;
					run_d   = '0;
				end
			end else begin
				run_d = '0;
			end
		end else if (pressed) begin
			run_d  = '0;
			held_d = inc_sat(held_q);
		end else if (fire) begin
			phase_d = 1'b0;
			run_d   = '0;
			held_d  = '0;
			best_d  = '0;
		end else begin
			run_d = run_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mask_s1 <= key_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			run_q   <= '0;
			held_q  <= '0;
			best_q  <= '0;
		end else if (advance) begin
			phase_q <= phase_d;
			run_q   <= run_d;
			held_q  <= held_d;
			best_q  <= best_d;
		end
	end

endmodule

// ----- design/kdlp_out_stage.sv -----
// ----------------------------------------------------------------------------
// Key debounce output stage
// Result register holding one item until the receiver takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kdlp_out_stage import kdlp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      res_valid,
	input  kdlp_res_t res,
	output logic      out_free,
	output logic      out_valid,
	input  logic      out_stall,
	output mask_t     key_code,
	output logic      long_press
);

	logic      valid_q;
	kdlp_res_t res_q;

	assign out_free   = !valid_q || !out_stall;
	assign out_valid  = valid_q;
	assign key_code   = res_q.key_code;
	assign long_press = res_q.long_press;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (out_free) begin
			valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && res_valid) begin
			res_q <= res;
		end
	end

endmodule

// ----- design/kdlp_checker.sv -----
// ----------------------------------------------------------------------------
// Key debounce port checker
// Port-level properties of the debouncer, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "key_debounce_long_press_unit_defines.svh"

module kdlp_checker import kdlp_pkg::*; (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input mask_t      key_code,
	input logic       long_press
);

	`KDLP_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(key_code) && $stable(long_press), "stalled result changed")
	`KDLP_ASSERT_IMP(a_code_nonzero, out_valid, key_code != '0, "result with empty key code")
	`KDLP_ASSERT_IMP(a_rise_after_item, $rose(out_valid), $past(in_valid && !in_stall, 2), "result without an item two cycles before")

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_chk (.*);
